### rtl/running_mean_stddev_stats_core_defines.svh
// assertion macros for the running statistics core
`ifndef RUNNING_MEAN_STDDEV_STATS_CORE_DEFINES_SVH
`define RUNNING_MEAN_STDDEV_STATS_CORE_DEFINES_SVH

// same-cycle implication, checked outside reset
`define RMSS_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked outside reset
`define RMSS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/rmss_pkg.sv
// shared types, constants and command codes of the running statistics core
`timescale 1ns / 1ps

package rmss_pkg;

    localparam int SAMPLE_BITS_DEF = 16;
    localparam int COUNT_BITS_DEF  = 32;
    localparam int FRAC_BITS_DEF   = 8;

    // fixed field widths
    localparam int SUM_W  = 48;
    localparam int SQ_W   = 63;
    localparam int FIX_W  = 24;
    localparam int QUO_W  = 48;
    localparam int STEP_W = 6;

    // iteration counts, loaded as count minus one
    localparam logic [STEP_W-1:0] MUL_STEPS_M1     = STEP_W'(4 - 1);
    localparam logic [STEP_W-1:0] DEV_DIV_STEPS_M1 = STEP_W'(QUO_W - 1);
    localparam logic [STEP_W-1:0] SQRT_STEPS_M1    = STEP_W'(QUO_W / 2 - 1);
    localparam logic [STEP_W-1:0] AVG_DIV_STEPS_M1 = STEP_W'(FIX_W - 1);

    localparam logic [FIX_W-1:0] AVG_POS_LIMIT = 24'h7FFFFF;
    localparam logic [FIX_W-1:0] AVG_NEG_LIMIT = 24'h800000;
    localparam logic [FIX_W-1:0] DEV_LIMIT     = 24'hFFFFFF;

    typedef struct packed {
        logic signed [15:0] sample;
        logic               restart;
    } t_in;

    typedef struct packed {
        logic        [31:0] count;
        logic signed [47:0] total;
        logic        [62:0] total_squares;
        logic signed [15:0] smallest;
        logic signed [15:0] largest;
        logic signed [23:0] average;
        logic        [23:0] deviation;
        logic               saturated;
    } t_out;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_CAPTURE,
        OP_UPDATE,
        OP_MUL_LOAD_A,
        OP_MUL_LOAD_B,
        OP_MUL_STEP,
        OP_SUB,
        OP_DEV_CHECK,
        OP_DIV_STEP,
        OP_SQRT_LOAD,
        OP_SQRT_STEP,
        OP_AVG_LOAD,
        OP_OUT_LOAD
    } t_dp_op;

    typedef struct packed {
        t_dp_op op;
    } t_dp_cmd;

    typedef struct packed {
        logic out_full;
    } t_dp_status;

    typedef enum logic [3:0] {
        S_IDLE,
        S_UPDATE,
        S_MULA_LOAD,
        S_MULA,
        S_MULB_LOAD,
        S_MULB,
        S_SUB,
        S_DEV_CHECK,
        S_DIV_DEV,
        S_SQRT_LOAD,
        S_SQRT,
        S_AVG_LOAD,
        S_DIV_AVG,
        S_DONE
    } t_state;

endpackage

### rtl/running_mean_stddev_stats_core.sv
// top level of the running mean and standard deviation core
`timescale 1ns / 1ps
//
// usage
// - input channel: i_in_valid / o_in_stall carry one sample and a restart flag
//   per transaction; a restart clears all statistics before that sample
// - output channel: o_out_valid / i_out_stall carry one result transaction per
//   sample: count, sum, sum of squares, min, max, mean and sample deviation
// - one sample is in work at a time: a new input transaction is stalled until
//   the result of the last one has been loaded into the output register
// - the work per sample runs through the shared restoring divider (48 quotient
//   bits for the deviation, 24 for the mean) and the 24-step square root, plus
//   four 48x16 partial-product steps for each of the two wide products
// - output register: a finished result waits there while the receiver stalls,
//   and the next sample is taken meanwhile; a further result waits in the
//   sequencer until the register is free
// - at the count limit the sample is dropped and the saturated flag is set
// - reset (synchronous, active low) clears the statistics and empties the
//   output register
//
module running_mean_stddev_stats_core #(
    parameter int SAMPLE_BITS = rmss_pkg::SAMPLE_BITS_DEF,
    parameter int COUNT_BITS  = rmss_pkg::COUNT_BITS_DEF,
    parameter int FRAC_BITS   = rmss_pkg::FRAC_BITS_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_stall,
    input  rmss_pkg::t_in  i_in_data,
    output logic           o_out_valid,
    input  logic           i_out_stall,
    output rmss_pkg::t_out o_out_data
);

`include "running_mean_stddev_stats_core_defines.svh"

    // command and status between sequencer and datapath
    rmss_pkg::t_dp_cmd    cmd;
    rmss_pkg::t_dp_status status;

    rmss_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_out_stall (i_out_stall),
        .i_status    (status),
        .o_cmd       (cmd)
    );

    rmss_dp #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .COUNT_BITS  (COUNT_BITS),
        .FRAC_BITS   (FRAC_BITS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (i_in_data),
        .i_cmd       (cmd),
        .i_out_stall (i_out_stall),
        .o_status    (status),
        .o_out_valid (o_out_valid),
        .o_out       (o_out_data)
    );

    // busy right after a transaction is taken
    `RMSS_ASSERT_NEXT(a_busy_after_accept, i_in_valid && !o_in_stall, o_in_stall, "not busy after accept")
    // a dropped sample shows a full count
    `RMSS_ASSERT_IMP(a_sat_count, o_out_valid && o_out_data.saturated, o_out_data.count == 32'({COUNT_BITS{1'b1}}), "saturated below limit")
    // every result follows at least one sample
    `RMSS_ASSERT_IMP(a_count_nonzero, o_out_valid, o_out_data.count != 32'd0, "zero count in result")
    // deviation needs two samples
    `RMSS_ASSERT_IMP(a_dev_small_n, o_out_valid && o_out_data.count < 32'd2, o_out_data.deviation == 24'd0, "deviation with one sample")

endmodule

### rtl/rmss_ctrl.sv
// sequencer of the running statistics core
`timescale 1ns / 1ps

module rmss_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  logic                i_out_stall,
    input  rmss_pkg::t_dp_status i_status,
    output rmss_pkg::t_dp_cmd   o_cmd
);

    rmss_pkg::t_state r_state, n_state;
    logic [rmss_pkg::STEP_W-1:0] r_step, n_step;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= rmss_pkg::S_IDLE;
            r_step  <= '0;
        end else begin
            r_state <= n_state;
            r_step  <= n_step;
        end
    end

    assign o_in_stall = (r_state != rmss_pkg::S_IDLE);

    always_comb begin
        n_state  = r_state;
        n_step   = r_step;
        o_cmd.op = rmss_pkg::OP_NONE;
        unique case (r_state)
            rmss_pkg::S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.op = rmss_pkg::OP_CAPTURE;
                    n_state  = rmss_pkg::S_UPDATE;
                end
            end
            rmss_pkg::S_UPDATE: begin
                o_cmd.op = rmss_pkg::OP_UPDATE;
                n_state  = rmss_pkg::S_MULA_LOAD;
            end
            rmss_pkg::S_MULA_LOAD: begin
                o_cmd.op = rmss_pkg::OP_MUL_LOAD_A;
                n_step   = rmss_pkg::MUL_STEPS_M1;
                n_state  = rmss_pkg::S_MULA;
            end
            rmss_pkg::S_MULA: begin
                o_cmd.op = rmss_pkg::OP_MUL_STEP;
                n_step   = r_step - 1'b1;
                if (r_step == '0) n_state = rmss_pkg::S_MULB_LOAD;
            end
            rmss_pkg::S_MULB_LOAD: begin
                o_cmd.op = rmss_pkg::OP_MUL_LOAD_B;
                n_step   = rmss_pkg::MUL_STEPS_M1;
                n_state  = rmss_pkg::S_MULB;
            end
            rmss_pkg::S_MULB: begin
                o_cmd.op = rmss_pkg::OP_MUL_STEP;
                n_step   = r_step - 1'b1;
                if (r_step == '0) n_state = rmss_pkg::S_SUB;
            end
            rmss_pkg::S_SUB: begin
                o_cmd.op = rmss_pkg::OP_SUB;
                n_state  = rmss_pkg::S_DEV_CHECK;
            end
            rmss_pkg::S_DEV_CHECK: begin
                o_cmd.op = rmss_pkg::OP_DEV_CHECK;
                n_step   = rmss_pkg::DEV_DIV_STEPS_M1;
                n_state  = rmss_pkg::S_DIV_DEV;
            end
            rmss_pkg::S_DIV_DEV: begin
                o_cmd.op = rmss_pkg::OP_DIV_STEP;
                n_step   = r_step - 1'b1;
                if (r_step == '0) n_state = rmss_pkg::S_SQRT_LOAD;
            end
            rmss_pkg::S_SQRT_LOAD: begin
                o_cmd.op = rmss_pkg::OP_SQRT_LOAD;
                n_step   = rmss_pkg::SQRT_STEPS_M1;
                n_state  = rmss_pkg::S_SQRT;
            end
            rmss_pkg::S_SQRT: begin
                o_cmd.op = rmss_pkg::OP_SQRT_STEP;
                n_step   = r_step - 1'b1;
                if (r_step == '0) n_state = rmss_pkg::S_AVG_LOAD;
            end
            rmss_pkg::S_AVG_LOAD: begin
                o_cmd.op = rmss_pkg::OP_AVG_LOAD;
                n_step   = rmss_pkg::AVG_DIV_STEPS_M1;
                n_state  = rmss_pkg::S_DIV_AVG;
            end
            rmss_pkg::S_DIV_AVG: begin
                o_cmd.op = rmss_pkg::OP_DIV_STEP;
                n_step   = r_step - 1'b1;
                if (r_step == '0) n_state = rmss_pkg::S_DONE;
            end
            rmss_pkg::S_DONE: begin
                if (!i_status.out_full || !i_out_stall) begin
                    o_cmd.op = rmss_pkg::OP_OUT_LOAD;
                    n_state  = rmss_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = rmss_pkg::S_IDLE;
            end
        endcase
    end

endmodule

### rtl/rmss_dp.sv
// accumulators, shared multiplier, divider, square root and output register
`timescale 1ns / 1ps

module rmss_dp #(
    parameter int SAMPLE_BITS = rmss_pkg::SAMPLE_BITS_DEF,
    parameter int COUNT_BITS  = rmss_pkg::COUNT_BITS_DEF,
    parameter int FRAC_BITS   = rmss_pkg::FRAC_BITS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  rmss_pkg::t_in        i_in,
    input  rmss_pkg::t_dp_cmd    i_cmd,
    input  logic                 i_out_stall,
    output rmss_pkg::t_dp_status o_status,
    output logic                 o_out_valid,
    output rmss_pkg::t_out       o_out
);

    localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

    // statistics
    logic        [15:0]             r_sample;
    logic                           r_restart;
    logic        [COUNT_BITS-1:0]   r_cnt;
    logic        [47:0]             r_sum;
    logic        [62:0]             r_sumsq;
    logic signed [SAMPLE_BITS-1:0]  r_min, r_max;
    logic                           r_sat;
    logic                           r_out_valid;
    rmss_pkg::t_out                 r_out;

    // working registers
    logic [47:0]  r_mag;
    logic         r_neg;
    logic [47:0]  r_mul_a;
    logic [63:0]  r_mul_b;
    logic [95:0]  r_acc, r_prod;
    logic [127:0] r_dshift;
    logic [63:0]  r_divisor;
    logic         r_dev_zero, r_dev_ovf, r_avg_ovf;
    logic [63:0]  r_rem, r_div_d;
    logic [47:0]  r_dvd, r_quo;
    logic [47:0]  r_sx, r_sres, r_sbit;

    // sample update
    logic        [23:0]             s_wide;
    logic signed [SAMPLE_BITS-1:0]  x_s;
    logic signed [2*SAMPLE_BITS-1:0] x_sq;
    logic        [COUNT_BITS-1:0]   cnt_b;
    logic        [47:0]             sum_b;
    logic        [62:0]             sumsq_b;

    assign s_wide  = {8'b0, r_sample};
    assign x_s     = s_wide[SAMPLE_BITS-1:0];
    assign x_sq    = x_s * x_s;
    assign cnt_b   = r_restart ? '0 : r_cnt;
    assign sum_b   = r_restart ? '0 : r_sum;
    assign sumsq_b = r_restart ? '0 : r_sumsq;

    // arithmetic steps
    logic [63:0]             pp;
    logic [96:0]             diff;
    logic [2*COUNT_BITS-1:0] nn;
    logic [63:0]             avg_dvd;
    logic [64:0]             div_t;
    logic                    div_ge;
    logic [47:0]             sq_try;
    logic [23:0]             q24;
    logic [23:0]             avg_val, dev_val;

    assign pp      = r_mul_a * r_mul_b[63:48];
    assign diff    = {1'b0, r_prod} - {1'b0, r_acc};
    assign nn      = r_cnt * (r_cnt - 1'b1);
    assign avg_dvd = 64'(r_mag) << FRAC_BITS;
    assign div_t   = {r_rem, r_dvd[47]};
    assign div_ge  = div_t >= {1'b0, r_div_d};
    assign sq_try  = r_sres + r_sbit;
    assign q24     = r_quo[23:0];

    always_comb begin
        if (r_cnt == '0) begin
            avg_val = '0;
        end else if (r_neg) begin
            if (r_avg_ovf || q24 > rmss_pkg::AVG_NEG_LIMIT) avg_val = rmss_pkg::AVG_NEG_LIMIT;
            else                                          avg_val = 24'(-q24);
        end else begin
            if (r_avg_ovf || q24 > rmss_pkg::AVG_POS_LIMIT) avg_val = rmss_pkg::AVG_POS_LIMIT;
            else                                          avg_val = q24;
        end
        if (r_dev_zero)     dev_val = '0;
        else if (r_dev_ovf) dev_val = rmss_pkg::DEV_LIMIT;
        else                dev_val = r_sres[23:0];
    end

    // statistics and output handshake
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt       <= '0;
            r_sum       <= '0;
            r_sumsq     <= '0;
            r_min       <= '0;
            r_max       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.op == rmss_pkg::OP_UPDATE) begin
                r_cnt   <= cnt_b;
                r_sum   <= sum_b;
                r_sumsq <= sumsq_b;
                if (r_restart) begin
                    r_min <= '0;
                    r_max <= '0;
                end
                if (cnt_b != COUNT_MAX) begin
                    r_sum   <= sum_b + 48'(x_s);
                    r_sumsq <= sumsq_b + 63'($unsigned(x_sq));
                    r_cnt   <= cnt_b + 1'b1;
                    if (cnt_b == '0) begin
                        r_min <= x_s;
                        r_max <= x_s;
                    end else begin
                        if (x_s < r_min) r_min <= x_s;
                        if (x_s > r_max) r_max <= x_s;
                    end
                end
            end
            if (i_cmd.op == rmss_pkg::OP_OUT_LOAD)  r_out_valid <= 1'b1;
            else if (r_out_valid && !i_out_stall) r_out_valid <= 1'b0;
        end
    end

    // working registers
    always_ff @(posedge i_clk) begin
        unique case (i_cmd.op)
            rmss_pkg::OP_CAPTURE: begin
                r_sample  <= i_in.sample;
                r_restart <= i_in.restart;
            end
            rmss_pkg::OP_UPDATE: begin
                r_sat <= (cnt_b == COUNT_MAX);
            end
            rmss_pkg::OP_MUL_LOAD_A: begin
                r_neg   <= r_sum[47];
                r_mag   <= r_sum[47] ? 48'(-r_sum) : r_sum;
                r_mul_a <= 48'(r_cnt);
                r_mul_b <= 64'(r_sumsq);
                r_acc   <= '0;
            end
            rmss_pkg::OP_MUL_LOAD_B: begin
                r_prod  <= r_acc;
                r_mul_a <= r_mag;
                r_mul_b <= 64'(r_mag);
                r_acc   <= '0;
            end
            rmss_pkg::OP_MUL_STEP: begin
                r_acc   <= {r_acc[79:0], 16'b0} + 96'(pp);
                r_mul_b <= {r_mul_b[47:0], 16'b0};
            end
            rmss_pkg::OP_SUB: begin
                r_dshift   <= 128'(diff[95:0]) << (2 * FRAC_BITS);
                r_dev_zero <= (r_cnt < COUNT_BITS'(2)) || diff[96];
                r_divisor  <= 64'(nn);
            end
            rmss_pkg::OP_DEV_CHECK: begin
                r_dev_ovf <= r_dshift[127:48] >= 80'(r_divisor);
                r_rem     <= r_dshift[111:48];
                r_dvd     <= r_dshift[47:0];
                r_div_d   <= r_divisor;
                r_quo     <= '0;
            end
            rmss_pkg::OP_DIV_STEP: begin
                r_rem <= div_ge ? 64'(div_t - {1'b0, r_div_d}) : div_t[63:0];
                r_dvd <= {r_dvd[46:0], 1'b0};
                r_quo <= {r_quo[46:0], div_ge};
            end
            rmss_pkg::OP_SQRT_LOAD: begin
                r_sx   <= r_quo;
                r_sres <= '0;
                r_sbit <= 48'(1) << 46;
            end
            rmss_pkg::OP_SQRT_STEP: begin
                if (r_sx >= sq_try) begin
                    r_sx   <= r_sx - sq_try;
                    r_sres <= (r_sres >> 1) + r_sbit;
                end else begin
                    r_sres <= r_sres >> 1;
                end
                r_sbit <= r_sbit >> 2;
            end
            rmss_pkg::OP_AVG_LOAD: begin
                r_avg_ovf <= avg_dvd[63:24] >= 40'(r_cnt);
                r_rem     <= 64'(avg_dvd[63:24]);
                r_dvd     <= {avg_dvd[23:0], 24'b0};
                r_div_d   <= 64'(r_cnt);
                r_quo     <= '0;
            end
            rmss_pkg::OP_OUT_LOAD: begin
                r_out.count         <= 32'(r_cnt);
                r_out.total         <= r_sum;
                r_out.total_squares <= r_sumsq;
                r_out.smallest      <= 16'(r_min);
                r_out.largest       <= 16'(r_max);
                r_out.average       <= avg_val;
                r_out.deviation     <= dev_val;
                r_out.saturated     <= r_sat;
            end
            default: begin
            end
        endcase
    end

    assign o_status.out_full = r_out_valid;
    assign o_out_valid       = r_out_valid;
    assign o_out             = r_out;

endmodule
